// ----- rtl/tksel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared widths, constants and types of the top-K score selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

   localparam int unsigned SCORE_W     = 32;
   localparam int unsigned OBJ_INDEX_W = 24;
   localparam int unsigned RANK_W      = 4;

   // -10000.0 in Q16.16
   localparam logic signed [SCORE_W-1:0] FLOOR_RESET = -32'sd655360000;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;    // rank the candidate beat and shift lower entries down
      logic shift_up;  // move every entry one rank up, bottom becomes empty
   } tksel_cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_DRAIN   = 2'b10
   } tksel_state_type;

endpackage

// ----- rtl/tksel_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_req_if
// Candidate channel: object index, Q16.16 score and end-of-scan mark.
// ----------------------------------------------------------------------------
interface tksel_req_if
   import tksel_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [OBJ_INDEX_W-1:0]    object_index;
   logic signed [SCORE_W-1:0] score;
   logic                      last_candidate;

   modport source (output valid, output object_index, output score,
                   output last_candidate, input ready);
   modport sink   (input valid, input object_index, input score,
                   input last_candidate, output ready);
endinterface

// ----- rtl/tksel_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_rsp_if
// Result channel: one beat per rank of the kept list.
// ----------------------------------------------------------------------------
interface tksel_rsp_if
   import tksel_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [RANK_W-1:0]         rank;
   logic [OBJ_INDEX_W-1:0]    best_index;
   logic signed [SCORE_W-1:0] best_score;
   logic                      slot_filled;
   logic                      end_of_list;

   modport source (output valid, output rank, output best_index, output best_score,
                   output slot_filled, output end_of_list, input ready);
   modport sink   (input valid, input rank, input best_index, input best_score,
                   input slot_filled, input end_of_list, output ready);
endinterface

// ----- rtl/tksel_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_csr_if
// Register write channel carrying the floor score.
// ----------------------------------------------------------------------------
interface tksel_csr_if
   import tksel_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/top_k_score_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_selector
// Keeps the TOP_COUNT best scored candidates of a scan in a chain of cells
// and emits the whole ranked list after the last candidate.
// ----------------------------------------------------------------------------
// Throughput: one candidate per cycle while collecting; every cell compares in parallel.
// After a last candidate the chain unloads one rank per cycle unless the result
// side stalls: TOP_COUNT result beats, no candidate taken meanwhile.
// The rank 0 beat is registered once the state has turned to drain, held
// back only while the previous list's final beat is still held.
// Reset: all ranks empty, floor at -10000.0, output register empty.
// ----------------------------------------------------------------------------
module top_k_score_selector
   import tksel_pkg::*;
#(
   parameter int unsigned TOP_COUNT  = 10,
   parameter int unsigned INDEX_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   tksel_req_if.sink   req_bus,
   tksel_rsp_if.source rsp_bus,
   tksel_csr_if.sink   csr_bus
);

   localparam int unsigned CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

   tksel_state_type           state_ff, state_in;
   logic [CNT_W-1:0]          emit_cnt_ff, emit_cnt_in;
   logic signed [SCORE_W-1:0] floor_ff;

   logic                      rsp_valid_ff;
   logic [RANK_W-1:0]         rank_ff;
   logic [OBJ_INDEX_W-1:0]    best_index_ff;
   logic signed [SCORE_W-1:0] best_score_ff;
   logic                      filled_ff;
   logic                      end_ff;

   tksel_cell_ctrl_type       ctrl;
   logic                      req_beat;
   logic                      drain_go;
   logic                      last_emit;
   logic [31:0]               cand_index_wide;
   logic [INDEX_BITS-1:0]     cand_index;
   logic [31:0]               head_index_wide;
   logic [31:0]               rank_wide;

   logic                      cell_ge    [TOP_COUNT];
   logic                      cell_hit   [TOP_COUNT+1];
   logic signed [SCORE_W-1:0] cell_score [TOP_COUNT+1];
   logic [INDEX_BITS-1:0]     cell_index [TOP_COUNT+1];
   logic                      cell_valid [TOP_COUNT+1];

   // ---- handshakes ---------------------------------------------------------
   assign req_bus.ready = state_ff == ST_COLLECT;
   assign csr_bus.ready = 1'b1;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign drain_go      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_bus.ready);
   assign last_emit     = emit_cnt_ff == CNT_W'(TOP_COUNT - 1);

   assign ctrl.insert   = req_beat;
   assign ctrl.shift_up = drain_go;

   assign cand_index_wide = 32'(req_bus.object_index);
   assign cand_index      = cand_index_wide[INDEX_BITS-1:0];

   // ---- cell chain ---------------------------------------------------------
   // below the bottom rank: nothing that stops the candidate, empty entry
   assign cell_hit[TOP_COUNT]   = 1'b0;
   assign cell_score[TOP_COUNT] = floor_ff;
   assign cell_index[TOP_COUNT] = '0;
   assign cell_valid[TOP_COUNT] = 1'b0;

   for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
      logic                      up_ge;
      logic signed [SCORE_W-1:0] up_score;
      logic [INDEX_BITS-1:0]     up_index;
      logic                      up_valid;

      if (i == 0) begin : g_head
         assign up_ge    = 1'b1;
         assign up_score = req_bus.score;
         assign up_index = cand_index;
         assign up_valid = 1'b1;
      end else begin : g_body
         assign up_ge    = cell_ge[i-1];
         assign up_score = cell_score[i-1];
         assign up_index = cell_index[i-1];
         assign up_valid = cell_valid[i-1];
      end

      tksel_cell #(
         .INDEX_BITS (INDEX_BITS),
         .IS_HEAD    (i == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cand_score  (req_bus.score),
         .cand_index  (cand_index),
         .floor_score (floor_ff),
         .upper_ge    (up_ge),
         .upper_score (up_score),
         .upper_index (up_index),
         .upper_valid (up_valid),
         .lower_hit   (cell_hit[i+1]),
         .lower_score (cell_score[i+1]),
         .lower_index (cell_index[i+1]),
         .lower_valid (cell_valid[i+1]),
         .ge          (cell_ge[i]),
         .hit         (cell_hit[i]),
         .score       (cell_score[i]),
         .index       (cell_index[i]),
         .valid       (cell_valid[i])
      );
   end

   // ---- sequencing ---------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      emit_cnt_in = emit_cnt_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_beat && req_bus.last_candidate) begin
               state_in    = ST_DRAIN;
               emit_cnt_in = '0;
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               emit_cnt_in = emit_cnt_ff + 1'b1;
               if (last_emit) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_COLLECT;
         emit_cnt_ff <= '0;
         floor_ff    <= FLOOR_RESET;
      end else begin
         state_ff    <= state_in;
         emit_cnt_ff <= emit_cnt_in;
         if (csr_bus.valid && csr_bus.ready) begin
            floor_ff <= csr_bus.data;
         end
      end
   end

   // ---- output register ----------------------------------------------------
   assign head_index_wide = 32'(cell_index[0]);
   assign rank_wide       = 32'(emit_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (drain_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      // load the head rank; an empty rank reads as index zero at the floor
      if (drain_go) begin
         rank_ff       <= rank_wide[RANK_W-1:0];
         filled_ff     <= cell_valid[0];
         end_ff        <= last_emit;
         best_index_ff <= cell_valid[0] ? head_index_wide[OBJ_INDEX_W-1:0] : '0;
         best_score_ff <= cell_valid[0] ? cell_score[0] : floor_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rank        = rank_ff;
   assign rsp_bus.best_index  = best_index_ff;
   assign rsp_bus.best_score  = best_score_ff;
   assign rsp_bus.slot_filled = filled_ff;
   assign rsp_bus.end_of_list = end_ff;

endmodule

// ----- rtl/tksel_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_cell
// One rank of the kept list: holds an entry, compares it with the candidate
// and takes the candidate, the entry above or the entry below as told.
// ----------------------------------------------------------------------------
module tksel_cell
   import tksel_pkg::*;
#(
   parameter int unsigned INDEX_BITS = 24,
   parameter bit          IS_HEAD    = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tksel_cell_ctrl_type       ctrl,
   input  logic signed [SCORE_W-1:0] cand_score,
   input  logic [INDEX_BITS-1:0]     cand_index,
   input  logic signed [SCORE_W-1:0] floor_score,
   // neighbour one rank up
   input  logic                      upper_ge,
   input  logic signed [SCORE_W-1:0] upper_score,
   input  logic [INDEX_BITS-1:0]     upper_index,
   input  logic                      upper_valid,
   // neighbour one rank down
   input  logic                      lower_hit,
   input  logic signed [SCORE_W-1:0] lower_score,
   input  logic [INDEX_BITS-1:0]     lower_index,
   input  logic                      lower_valid,
   // own state
   output logic                      ge,
   output logic                      hit,
   output logic signed [SCORE_W-1:0] score,
   output logic [INDEX_BITS-1:0]     index,
   output logic                      valid
);

   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [INDEX_BITS-1:0]     index_ff, index_in;
   logic                      valid_ff, valid_in;
   logic signed [SCORE_W-1:0] slot_score;

   // an empty slot counts as the current floor
   assign slot_score = valid_ff ? score_ff : floor_score;
   assign ge         = slot_score >= cand_score;
   // this rank or one below holds a score not beaten by the candidate
   assign hit        = ge | lower_hit;

   always_comb begin
      score_in = score_ff;
      index_in = index_ff;
      valid_in = valid_ff;
      if (ctrl.insert && !hit) begin
         if (IS_HEAD || upper_ge) begin
            score_in = cand_score;
            index_in = cand_index;
            valid_in = 1'b1;
         end else begin
            score_in = upper_score;
            index_in = upper_index;
            valid_in = upper_valid;
         end
      end else if (ctrl.shift_up) begin
         score_in = lower_score;
         index_in = lower_index;
         valid_in = lower_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      score_ff <= score_in;
      index_ff <= index_in;
   end

   assign score = score_ff;
   assign index = index_ff;
   assign valid = valid_ff;

endmodule

// ----- tb/sv/tb_top_k_score_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_score_selector
// Self-checking bench for the top-K score selector. Candidates stream in with
// random gaps while the result side stalls at random. A behavioural ranking
// list tracks every accepted candidate and floor write. When a last
// candidate is accepted, the bench queues the full ranked list it expects.
// Each result beat is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_top_k_score_selector
   import tksel_pkg::*;
();

   localparam int TOP_K    = 10;
   localparam int OBJ_BITS = 24;

   typedef struct {
      logic [RANK_W-1:0]         rank;
      logic [OBJ_INDEX_W-1:0]    obj;
      logic signed [SCORE_W-1:0] score;
      logic                      filled;
      logic                      eol;
   } ranked_slot_type;

   logic clock;
   logic reset;

   tksel_req_if req_if ();
   tksel_rsp_if rsp_if ();
   tksel_csr_if csr_if ();

   top_k_score_selector #(
      .TOP_COUNT  (TOP_K),
      .INDEX_BITS (OBJ_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // behavioural copy of the ranking store
   logic signed [SCORE_W-1:0] floor_q;
   logic signed [SCORE_W-1:0] kept_score [TOP_K];
   logic [OBJ_INDEX_W-1:0]    kept_obj   [TOP_K];
   logic                      kept_used  [TOP_K];
   ranked_slot_type           ranked_list_q [$];

   bit steady_run;
   int mismatch_count;
   int beats_checked;
   int candidates_sent;
   int scans_closed;
   int floor_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("run timed out with %0d ranked beats pending", ranked_list_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= steady_run || ($urandom_range(0, 99) >= 12);
      end
   end

   function automatic logic signed [SCORE_W-1:0] slot_value(input int i);
      return kept_used[i] ? kept_score[i] : floor_q;
   endfunction

   function automatic void clear_ranking();
      for (int i = 0; i < TOP_K; i++) begin
         kept_score[i] = floor_q;
         kept_obj[i]   = '0;
         kept_used[i]  = 1'b0;
      end
   endfunction

   // walk up from the bottom rank; a tie leaves the older entry ahead
   function automatic void rank_candidate(input logic [OBJ_INDEX_W-1:0]    obj,
                                          input logic signed [SCORE_W-1:0] sc,
                                          input logic                      last);
      int pos;
      ranked_slot_type slot;
      pos = TOP_K - 1;
      while (pos >= 0 && slot_value(pos) < sc)
         pos--;
      if (pos != TOP_K - 1) begin
         for (int j = TOP_K - 2; j > pos; j--) begin
            kept_score[j+1] = kept_score[j];
            kept_obj[j+1]   = kept_obj[j];
            kept_used[j+1]  = kept_used[j];
         end
         kept_score[pos+1] = sc;
         kept_obj[pos+1]   = obj;
         kept_used[pos+1]  = 1'b1;
      end
      if (last) begin
         for (int j = 0; j < TOP_K; j++) begin
            slot.rank   = RANK_W'(j);
            slot.obj    = kept_used[j] ? kept_obj[j] : '0;
            slot.score  = kept_used[j] ? kept_score[j] : floor_q;
            slot.filled = kept_used[j];
            slot.eol    = (j == TOP_K - 1);
            ranked_list_q.push_back(slot);
         end
         clear_ranking();
         scans_closed++;
      end
   endfunction

   function automatic void check_ranked_beat();
      ranked_slot_type exp_slot;
      if (ranked_list_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result beat: rank=%0d idx=%h score=%h",
                     rsp_if.rank, rsp_if.best_index, rsp_if.best_score);
         return;
      end
      exp_slot = ranked_list_q.pop_front();
      beats_checked++;
      if (rsp_if.rank !== exp_slot.rank || rsp_if.best_index !== exp_slot.obj ||
          rsp_if.best_score !== exp_slot.score ||
          rsp_if.slot_filled !== exp_slot.filled ||
          rsp_if.end_of_list !== exp_slot.eol) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("rank beat error: exp rank=%0d idx=%h score=%h filled=%b eol=%b",
                     exp_slot.rank, exp_slot.obj, exp_slot.score, exp_slot.filled,
                     exp_slot.eol, " | got rank=%0d idx=%h score=%h filled=%b eol=%b",
                     rsp_if.rank, rsp_if.best_index, rsp_if.best_score,
                     rsp_if.slot_filled, rsp_if.end_of_list);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            floor_q = csr_if.data;
         if (req_if.valid && req_if.ready)
            rank_candidate(req_if.object_index, req_if.score, req_if.last_candidate);
         if (rsp_if.valid && rsp_if.ready)
            check_ranked_beat();
      end
   end

   task automatic send_candidate(input logic [OBJ_INDEX_W-1:0]    obj,
                                 input logic signed [SCORE_W-1:0] sc,
                                 input logic                      last);
      if (!steady_run && $urandom_range(0, 99) < 12) begin
         req_if.valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < 40);
      end
      req_if.valid          <= 1'b1;
      req_if.object_index   <= obj;
      req_if.score          <= sc;
      req_if.last_candidate <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      candidates_sent++;
   endtask

   // hold the sender until every ranked beat is back and the chain is quiet
   task automatic settle_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (ranked_list_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_floor(input logic signed [SCORE_W-1:0] value);
      settle_idle();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      floor_writes++;
   endtask

   function automatic logic signed [SCORE_W-1:0] pick_floor();
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return FLOOR_RESET;
         3:       return $signed(($urandom_range(0, 15) - 8) << 16);
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score(input int mode);
      int offset;
      offset = $urandom_range(0, 6) - 3;
      case (mode)
         0:       return $signed($urandom());
         1:       return $signed(($urandom_range(0, 7) - 4) << 16); // crowd of ties
         default: return floor_q + offset;
      endcase
   endfunction

   task automatic test_reset_floor();
      // single-candidate scans against the reset floor: above, equal, below
      send_candidate(24'h000001, 32'sh0001_0000, 1'b1);
      send_candidate(24'h000002, FLOOR_RESET, 1'b1);
      send_candidate(24'h000003, FLOOR_RESET - 1, 1'b1);
   endtask

   task automatic test_ties_and_extremes();
      send_candidate(24'h000000, 32'sh7FFF_FFFF, 1'b0);
      send_candidate(24'hFFFFFF, 32'sh8000_0000, 1'b0);
      send_candidate(24'h000011, 32'sh0005_0000, 1'b0);
      send_candidate(24'h000022, 32'sh0005_0000, 1'b0);
      send_candidate(24'h000033, 32'sh0005_0000, 1'b0);
      // overfill the list so the bottom entries drop out
      for (int i = 1; i <= 7; i++)
         send_candidate(OBJ_INDEX_W'(24'h800000 + i), $signed(i << 16), 1'b0);
      send_candidate(24'hABCDEF, 32'sh0005_0000, 1'b1);
   endtask

   task automatic test_floor_mid_scan();
      send_candidate(24'h000100, -32'sd327680000, 1'b0);
      write_floor(32'sh0000_0000);
      send_candidate(24'h000200, 32'sh0000_0000, 1'b0);
      send_candidate(24'h000300, 32'sh0001_0000, 1'b0);
      send_candidate(24'h000400, -32'sd1, 1'b1);
   endtask

   task automatic test_floor_extremes();
      write_floor(32'sh8000_0000);
      send_candidate(24'h0F0F0F, 32'sh8000_0001, 1'b0);
      send_candidate(24'h5A5A5A, 32'sh8000_0000, 1'b1);
      write_floor(32'sh7FFF_FFFF);
      send_candidate(24'h123456, 32'sh7FFF_FFFF, 1'b0);
      send_candidate(24'hA5A5A5, $signed($urandom()), 1'b1);
      write_floor(FLOOR_RESET);
   endtask

   task automatic test_random_scans(input int n_items);
      int sent;
      int scan_len;
      int mode;
      sent = 0;
      while (sent < n_items) begin
         if (!steady_run && sent >= n_items / 3 && sent < n_items / 2) begin
            settle_idle();
            steady_run = 1'b1;
         end else if (sent >= n_items / 2) begin
            steady_run = 1'b0;
         end
         if ($urandom_range(0, 3) == 0)
            write_floor(pick_floor());
         scan_len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30)
                                                : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         for (int k = 0; k < scan_len; k++) begin
            if (k == scan_len / 2 && k != 0 && $urandom_range(0, 7) == 0)
               write_floor(pick_floor());
            send_candidate(OBJ_INDEX_W'($urandom()), pick_score(mode),
                           k == scan_len - 1);
            sent++;
         end
      end
      steady_run = 1'b0;
   endtask

   initial begin
      steady_run     = 1'b0;
      mismatch_count = 0;
      beats_checked  = 0;
      candidates_sent = 0;
      scans_closed   = 0;
      floor_writes   = 0;
      floor_q        = FLOOR_RESET;
      clear_ranking();
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.object_index   <= '0;
      req_if.score          <= '0;
      req_if.last_candidate <= 1'b0;
      csr_if.valid          <= 1'b0;
      csr_if.data           <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_floor();
      test_ties_and_extremes();
      test_floor_mid_scan();
      test_floor_extremes();
      test_random_scans(230);

      settle_idle();
      repeat (20) @(posedge clock);
      $display("ran %0d candidates in %0d scans with %0d floor writes",
               candidates_sent, scans_closed, floor_writes);
      $display("checked %0d ranked beats, %0d mismatches", beats_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
